/* hw/rtl/pva_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_pkg
// Shared types, sizes and the note-to-phase-increment table of the voice
// allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

  localparam int VOICES         = 8;
  localparam int TABLE_POINTS   = 4096;
  localparam int SAMPLE_RATE_HZ = 32000;

  localparam int IDX_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int NOTE_W  = 7;
  localparam int VEL_W   = 7;
  localparam int VIDX_W  = 3;
  localparam int INC_W   = 11;
  localparam int NOTES   = 1 << NOTE_W;

  localparam int              Q_FRAC_BITS = 24;
  localparam longint unsigned INC_MAX     = 64'd2047;

  // Note frequencies of one octave starting at note 0, unsigned Q24.
  localparam longint unsigned NOTE_FREQ_Q24 [12] = '{
    64'd137167144, 64'd145323527, 64'd153964914, 64'd163120144,
    64'd172819773, 64'd183096171, 64'd193983636, 64'd205518503,
    64'd217739269, 64'd230686720, 64'd244404066, 64'd258937088
  };

  typedef logic [INC_W-1:0] inc_rom_t [NOTES];

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic load_in;
    logic exec;
  } pva_cmd_t;

  function automatic inc_rom_t build_inc_rom();
    inc_rom_t        rom;
    longint unsigned freq;
    longint unsigned inc;
    int              n;
    for (int o = 0; o < 11; o++) begin
      for (int k = 0; k < 12; k++) begin
        n = o * 12 + k;
        if (n < NOTES) begin
          freq = NOTE_FREQ_Q24[k] << o;
          inc  = ((freq * TABLE_POINTS) / SAMPLE_RATE_HZ) >> Q_FRAC_BITS;
          if (inc > INC_MAX) begin
            inc = INC_MAX;
          end
          rom[NOTE_W'(n)] = INC_W'(inc);
        end
      end
    end
    return rom;
  endfunction

  localparam inc_rom_t INC_ROM = build_inc_rom();

endpackage

/* hw/rtl/pva_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_ctrl
// Sequencer of the voice allocator: takes an event, runs one update of the
// voice table and hands the result register to the output channel.
// ----------------------------------------------------------------------------
module pva_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pva_pkg::pva_cmd_t cmd_o
);

  pva_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pva_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o.load_in = 1'b0;
    cmd_o.exec    = 1'b0;
    in_ready_o    = 1'b0;
    case (state_q)
      pva_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = pva_pkg::ST_EXEC;
        end
      end
      pva_pkg::ST_EXEC: begin
        // hold until the result register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = pva_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pva_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/pva_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_datapath
// Voice table, free and match search, increment lookup and result register.
// ----------------------------------------------------------------------------
module pva_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pva_pkg::pva_cmd_t           cmd_i,
  input  logic [pva_pkg::NOTE_W-1:0]  note_i,
  input  logic [pva_pkg::VEL_W-1:0]   velocity_i,
  output logic                        found_o,
  output logic [pva_pkg::VIDX_W-1:0]  voice_index_o,
  output logic                        is_note_on_o,
  output logic [pva_pkg::INC_W-1:0]   phase_increment_o
);

  logic [pva_pkg::NOTE_W-1:0] note_q;
  logic [pva_pkg::VEL_W-1:0]  vel_q;

  logic [pva_pkg::VOICES-1:0] active_q;
  logic [pva_pkg::NOTE_W-1:0] voice_note_q [pva_pkg::VOICES];

  logic                       note_on;
  logic                       free_hit;
  logic                       match_hit;
  logic [pva_pkg::IDX_W-1:0]  free_idx;
  logic [pva_pkg::IDX_W-1:0]  match_idx;

  logic                       found_q;
  logic [pva_pkg::VIDX_W-1:0] vidx_q;
  logic                       on_q;
  logic [pva_pkg::INC_W-1:0]  inc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      note_q <= note_i;
      vel_q  <= velocity_i;
    end
  end

  assign note_on = (vel_q != '0);

  // lowest free voice and lowest active voice holding the note
  always_comb begin
    free_hit  = 1'b0;
    match_hit = 1'b0;
    free_idx  = '0;
    match_idx = '0;
    for (int i = pva_pkg::VOICES - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_hit = 1'b1;
        free_idx = pva_pkg::IDX_W'(i);
      end
      if (active_q[i] && (voice_note_q[i] == note_q)) begin
        match_hit = 1'b1;
        match_idx = pva_pkg::IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      for (int i = 0; i < pva_pkg::VOICES; i++) begin
        voice_note_q[i] <= '0;
      end
    end else if (cmd_i.exec) begin
      if (note_on && free_hit) begin
        active_q[free_idx]     <= 1'b1;
        voice_note_q[free_idx] <= note_q;
      end else if (!note_on && match_hit) begin
        active_q[match_idx]     <= 1'b0;
        voice_note_q[match_idx] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      on_q <= note_on;
      if (note_on) begin
        found_q <= free_hit;
        vidx_q  <= free_hit ? pva_pkg::VIDX_W'(free_idx) : '0;
        inc_q   <= free_hit ? pva_pkg::INC_ROM[note_q] : '0;
      end else begin
        found_q <= match_hit;
        vidx_q  <= match_hit ? pva_pkg::VIDX_W'(match_idx) : '0;
        inc_q   <= '0;
      end
    end
  end

  assign found_o           = found_q;
  assign voice_index_o     = vidx_q;
  assign is_note_on_o      = on_q;
  assign phase_increment_o = inc_q;

endmodule

/* hw/rtl/polyphonic_voice_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator
// Note-on/note-off voice allocator with phase increment lookup.
// ----------------------------------------------------------------------------
// Each note event gives one result. An event is taken in the idle state and
// the voice table is searched and updated in the execute state, so a new event
// is taken only after the last one is updated; the result sits in an output
// register and the next event is taken while it waits. A full result register
// that is not drained holds the update of the following event. Note-on claims
// the lowest free voice and returns the increment from a 128-entry table;
// note-off releases the lowest active voice holding the note.
module polyphonic_voice_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [pva_pkg::NOTE_W-1:0]  note_i,
  input  logic [pva_pkg::VEL_W-1:0]   velocity_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic [pva_pkg::VIDX_W-1:0]  voice_index_o,
  output logic                        is_note_on_o,
  output logic [pva_pkg::INC_W-1:0]   phase_increment_o
);

  pva_pkg::pva_cmd_t cmd;

  pva_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  pva_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .note_i            (note_i),
    .velocity_i        (velocity_i),
    .found_o           (found_o),
    .voice_index_o     (voice_index_o),
    .is_note_on_o      (is_note_on_o),
    .phase_increment_o (phase_increment_o)
  );

endmodule

/* hw/rtl/pva_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_checker
// Port-level checks of the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pva_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [pva_pkg::NOTE_W-1:0]  note_i,
  input logic [pva_pkg::VEL_W-1:0]   velocity_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        found_o,
  input logic [pva_pkg::VIDX_W-1:0]  voice_index_o,
  input logic                        is_note_on_o,
  input logic [pva_pkg::INC_W-1:0]   phase_increment_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_o)
      && $stable(voice_index_o) && $stable(phase_increment_o))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second event taken during update");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> voice_index_o == '0 && phase_increment_o == '0)
    else $error("miss result carries nonzero fields");

  a_off_no_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_note_on_o |-> phase_increment_o == '0)
    else $error("note-off result carries an increment");

  a_on_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o && is_note_on_o |-> phase_increment_o != '0)
    else $error("assigned voice without increment");

endmodule

bind polyphonic_voice_allocator pva_checker u_pva_checker (.*);

/* tb/polyphonic_voice_allocator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator_tb
// Self-checking bench for the voice allocator. Note events go in over a
// valid/ready channel, and results are checked field by field against an
// in-bench model of the voice table and the phase increment math. The bench
// runs directed corner cases first, then random event streams with and without
// backpressure, including a pause until every result has drained.
// ----------------------------------------------------------------------------
module polyphonic_voice_allocator_tb;

  typedef struct packed {
    logic                       found;
    logic [pva_pkg::VIDX_W-1:0] voice_index;
    logic                       is_note_on;
    logic [pva_pkg::INC_W-1:0]  phase_increment;
  } voice_result_t;

  localparam longint unsigned OCTAVE_BASE_Q24 [12] = '{
    64'd137167144, 64'd145323527, 64'd153964914, 64'd163120144,
    64'd172819773, 64'd183096171, 64'd193983636, 64'd205518503,
    64'd217739269, 64'd230686720, 64'd244404066, 64'd258937088
  };
  localparam int STALL_PCT = 17;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [pva_pkg::NOTE_W-1:0] note_i;
  logic [pva_pkg::VEL_W-1:0]  velocity_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic                       found_o;
  logic [pva_pkg::VIDX_W-1:0] voice_index_o;
  logic                       is_note_on_o;
  logic [pva_pkg::INC_W-1:0]  phase_increment_o;

  bit                         voice_busy [pva_pkg::VOICES];
  logic [pva_pkg::NOTE_W-1:0] voice_held [pva_pkg::VOICES];
  voice_result_t              expected_results [$];

  bit sender_stall_en;
  bit sink_stall_en;
  int mismatch_count;
  int transfers_in;
  int on_assigned;
  int on_refused;
  int off_released;
  int off_unmatched;

  polyphonic_voice_allocator dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .note_i            (note_i),
    .velocity_i        (velocity_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .found_o           (found_o),
    .voice_index_o     (voice_index_o),
    .is_note_on_o      (is_note_on_o),
    .phase_increment_o (phase_increment_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic logic [pva_pkg::INC_W-1:0] phase_increment_of(
    input logic [pva_pkg::NOTE_W-1:0] note
  );
    longint unsigned freq;
    int              octave;
    int              step;
    octave = note / 12;
    step   = note % 12;
    freq   = OCTAVE_BASE_Q24[step] << octave;
    freq   = ((freq * pva_pkg::TABLE_POINTS) / pva_pkg::SAMPLE_RATE_HZ) >> 24;
    if (freq > 64'd2047) begin
      freq = 64'd2047;
    end
    return freq[pva_pkg::INC_W-1:0];
  endfunction

  function automatic voice_result_t allocate_voice(input logic [pva_pkg::NOTE_W-1:0] note,
                                                   input logic [pva_pkg::VEL_W-1:0]  vel);
    voice_result_t r;
    bit            done;
    r            = '0;
    r.is_note_on = (vel != 0);
    done         = 1'b0;
    for (int v = 0; v < pva_pkg::VOICES; v++) begin
      if (!done && vel != 0 && !voice_busy[v]) begin
        voice_busy[v]     = 1'b1;
        voice_held[v]     = note;
        r.found           = 1'b1;
        r.voice_index     = pva_pkg::VIDX_W'(v);
        r.phase_increment = phase_increment_of(note);
        done              = 1'b1;
      end else if (!done && vel == 0 && voice_busy[v] && voice_held[v] == note) begin
        voice_busy[v] = 1'b0;
        voice_held[v] = '0;
        r.found       = 1'b1;
        r.voice_index = pva_pkg::VIDX_W'(v);
        done          = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic send_event(input logic [pva_pkg::NOTE_W-1:0] note,
                            input logic [pva_pkg::VEL_W-1:0]  vel);
    while (sender_stall_en && $urandom_range(0, 99) < STALL_PCT) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    note_i     <= note;
    velocity_i <= vel;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    expected_results.push_back(allocate_voice(note, vel));
    transfers_in++;
  endtask

  task automatic send_random_event();
    logic [pva_pkg::NOTE_W-1:0] note;
    logic [pva_pkg::VEL_W-1:0]  vel;
    int                         pick;
    int                         v;
    pick = $urandom_range(0, 99);
    note = pva_pkg::NOTE_W'($urandom_range(0, 127));
    vel  = pva_pkg::VEL_W'($urandom_range(1, 127));
    if (pick < 10) begin
      vel = pva_pkg::VEL_W'($urandom_range(0, 127));
    end else if (pick >= 55) begin
      vel = '0;
      v   = $urandom_range(0, pva_pkg::VOICES - 1);
      if (pick < 90 && voice_busy[v]) begin
        note = voice_held[v];
      end
    end
    send_event(note, vel);
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= !sink_stall_en || ($urandom_range(0, 99) >= STALL_PCT);
  end

  always @(posedge clk_i) begin
    voice_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: found=%0d voice=%0d on=%0d inc=%0d",
               found_o, voice_index_o, is_note_on_o, phase_increment_o);
        mismatch_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (found_o !== exp_r.found) begin
          $error("found: expected %0d, got %0d", exp_r.found, found_o);
          mismatch_count++;
        end
        if (voice_index_o !== exp_r.voice_index) begin
          $error("voice_index: expected %0d, got %0d", exp_r.voice_index, voice_index_o);
          mismatch_count++;
        end
        if (is_note_on_o !== exp_r.is_note_on) begin
          $error("is_note_on: expected %0d, got %0d", exp_r.is_note_on, is_note_on_o);
          mismatch_count++;
        end
        if (phase_increment_o !== exp_r.phase_increment) begin
          $error("phase_increment: expected %0d, got %0d",
                 exp_r.phase_increment, phase_increment_o);
          mismatch_count++;
        end
        if (exp_r.is_note_on && exp_r.found) on_assigned++;
        if (exp_r.is_note_on && !exp_r.found) on_refused++;
        if (!exp_r.is_note_on && exp_r.found) off_released++;
        if (!exp_r.is_note_on && !exp_r.found) off_unmatched++;
      end
    end
  end

  task automatic test_directed();
    send_event(7'd0, 7'd0);
    send_event(7'd0, 7'd1);
    send_event(7'd127, 7'd127);
    send_event(7'd60, 7'd64);
    send_event(7'd60, 7'd100);
    send_event(7'd12, 7'd2);
    send_event(7'd24, 7'd85);
    send_event(7'd36, 7'd42);
    send_event(7'd119, 7'd127);
    send_event(7'd70, 7'd90);
    send_event(7'd60, 7'd0);
    send_event(7'd60, 7'd0);
    send_event(7'd60, 7'd0);
    send_event(7'd5, 7'd127);
    send_event(7'd127, 7'd0);
    send_event(7'd0, 7'd0);
    send_event(7'd99, 7'd0);
    send_event(7'd0, 7'd33);
    send_event(7'd11, 7'd127);
    for (int v = 0; v < pva_pkg::VOICES; v++) begin
      if (voice_busy[v]) begin
        send_event(voice_held[v], 7'd0);
      end
    end
  endtask

  task automatic test_random_events(input int count);
    sender_stall_en = 1'b1;
    sink_stall_en   = 1'b1;
    repeat (count) send_random_event();
  endtask

  task automatic test_drain_pause();
    sender_stall_en = 1'b1;
    sink_stall_en   = 1'b1;
    repeat (20) send_random_event();
    hold_until_drained();
    repeat (20) send_random_event();
  endtask

  task automatic test_unstalled_burst(input int count);
    sender_stall_en = 1'b0;
    sink_stall_en   = 1'b0;
    repeat (count) send_random_event();
    sender_stall_en = 1'b1;
    sink_stall_en   = 1'b1;
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    note_i          = '0;
    velocity_i      = '0;
    out_ready_i     = 1'b0;
    sender_stall_en = 1'b1;
    sink_stall_en   = 1'b1;
    for (int v = 0; v < pva_pkg::VOICES; v++) begin
      voice_busy[v] = 1'b0;
      voice_held[v] = '0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_events(600);
    test_drain_pause();
    test_unstalled_burst(300);
    test_random_events(560);

    hold_until_drained();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d note events: %0d voices claimed, %0d refused with all busy,",
             transfers_in, on_assigned, on_refused);
    $display("%0d voices released and %0d note-offs with no matching voice.",
             off_released, off_unmatched);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

endmodule
